@@ rtl/straight_drive_steering_mixer_assert.svh @@
// assertion macros shared by the straight drive mixer modules
// depends on nothing; included by modules that carry checks
`ifndef STRAIGHT_DRIVE_STEERING_MIXER_ASSERT_SVH
`define STRAIGHT_DRIVE_STEERING_MIXER_ASSERT_SVH

// same-cycle implication, disabled during reset
`define SDSM_ASSERT_NOW(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sdsm check failed: same-cycle rule");

// next-cycle implication, disabled during reset
`define SDSM_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sdsm check failed: next-cycle rule");

`endif

@@ rtl/sdsm_pkg.sv @@
// types and constants for the straight drive steering mixer
// no dependencies; imported by every rtl module of the block
package sdsm_pkg;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 23;
    localparam int S_TDATA_W   = 152;
    localparam int M_TDATA_W   = 56;

    localparam logic [11:0] WALL_PRESENT_LEVEL = 12'd100;
    localparam int unsigned FAULT_GRACE_MS     = 500;
    // travel above 300 counts means |l| + |r| of at least 602
    localparam int unsigned ENC_TRAV_SUM_MAX   = 601;
    localparam int unsigned ENC_AVG_WINDOW     = 50;

    // floor(x / 10) = (x * 6554) >> 16 for x below 16384
    localparam logic [12:0] DIV10_RECIP = 13'd6554;
    localparam int          DIV10_SHIFT = 16;
    // floor(x / 5) = (x * 0xCCCCCCCD) >> 34 for any 32-bit x
    localparam logic [31:0] DIV5_RECIP  = 32'hCCCC_CCCD;
    localparam int          DIV5_SHIFT  = 34;

    typedef enum logic [2:0] {
        ST_DRIVING  = 3'd0,
        ST_DONE     = 3'd1,
        ST_TIMEOUT  = 3'd2,
        ST_ENCFAULT = 3'd3,
        ST_FRONT    = 3'd4,
        ST_STARTED  = 3'd5,
        ST_IDLE     = 3'd6
    } status_t;

    typedef enum logic {
        FUNC_START  = 1'b0,
        FUNC_SAMPLE = 1'b1
    } func_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_TARGET_COUNTS    = 3'd0,
        REG_CRUISE_PWM       = 3'd1,
        REG_TIMEOUT_MS       = 3'd2,
        REG_PWM_MAX          = 3'd3,
        REG_END_SLOW_PWM     = 3'd4,
        REG_SLOW_ZONE_COUNTS = 3'd5,
        REG_FRONT_STOP_LEVEL = 3'd6,
        REG_SIDE_TARGET      = 3'd7
    } cfg_reg_t;

    typedef struct packed {
        logic [22:0] target_counts;
        logic [7:0]  cruise_pwm;
        logic [15:0] timeout_ms;
        logic [9:0]  pwm_max;
        logic [7:0]  end_slow_pwm;
        logic [15:0] slow_zone_counts;
        logic [11:0] front_stop_level;
        logic [11:0] side_target_level;
    } cfg_t;

    typedef struct packed {
        func_t              func;
        logic [31:0]        time_ms;
        logic signed [31:0] enc_left;
        logic signed [31:0] enc_right;
        logic signed [15:0] heading;
        logic [11:0]        ir_left;
        logic [11:0]        ir_right;
        logic [11:0]        ir_front;
    } item_t;

    // handed from the control stage to the mixing stages
    typedef struct packed {
        status_t            status;
        logic signed [31:0] remaining;
        logic [7:0]         base;
        logic signed [14:0] corr_h;
        logic signed [12:0] ir_diff;
        logic [30:0]        enc_diff_q4;
        logic               enc_diff_neg;
    } mid_t;

    typedef struct packed {
        logic signed [10:0] pwm_left;
        logic signed [10:0] pwm_right;
        status_t            status;
        logic signed [31:0] remaining;
    } result_t;

endpackage

@@ rtl/sdsm_cfg.sv @@
// configuration register file of the straight drive steering mixer
// depends on sdsm_pkg; values are truncated to each register's width
module sdsm_cfg
    import sdsm_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output cfg_t                   cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_TARGET_COUNTS:    cfg_next.target_counts     = cfg_data[22:0];
                REG_CRUISE_PWM:       cfg_next.cruise_pwm        = cfg_data[7:0];
                REG_TIMEOUT_MS:       cfg_next.timeout_ms        = cfg_data[15:0];
                REG_PWM_MAX:          cfg_next.pwm_max           = cfg_data[9:0];
                REG_END_SLOW_PWM:     cfg_next.end_slow_pwm      = cfg_data[7:0];
                REG_SLOW_ZONE_COUNTS: cfg_next.slow_zone_counts  = cfg_data[15:0];
                REG_FRONT_STOP_LEVEL: cfg_next.front_stop_level  = cfg_data[11:0];
                REG_SIDE_TARGET:      cfg_next.side_target_level = cfg_data[11:0];
                default:              cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.target_counts     <= 23'd0;
            cfg_reg.cruise_pwm        <= 8'd0;
            cfg_reg.timeout_ms        <= 16'd2000;
            cfg_reg.pwm_max           <= 10'd255;
            cfg_reg.end_slow_pwm      <= 8'd60;
            cfg_reg.slow_zone_counts  <= 16'd0;
            cfg_reg.front_stop_level  <= 12'd4095;
            cfg_reg.side_target_level <= 12'd0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

@@ rtl/sdsm_ctrl.sv @@
// control stage: move state, travel and timing checks, ir cache, correction terms
// depends on sdsm_pkg and the assertion macro header
`include "straight_drive_steering_mixer_assert.svh"

module sdsm_ctrl
    import sdsm_pkg::*;
#(
    parameter int IR_REFRESH_EVERY = 3
)
(
    input  logic  clk,
    input  logic  rst_n,
    input  cfg_t  cfg,
    input  logic  item_valid,
    output logic  item_ready,
    input  item_t item,
    output logic  mid_valid,
    input  logic  mid_ready,
    output mid_t  mid
);

    localparam int PHASE_W = $clog2(IR_REFRESH_EVERY + 1);
    localparam logic [PHASE_W-1:0] PHASE_LAST = PHASE_W'(IR_REFRESH_EVERY - 1);

    logic               active_reg, active_next;
    logic signed [31:0] left_origin_reg, left_origin_next;
    logic signed [31:0] right_origin_reg, right_origin_next;
    logic signed [15:0] heading_target_reg, heading_target_next;
    logic [31:0]        start_time_reg, start_time_next;
    logic [PHASE_W-1:0] phase_reg, phase_next, phase_inc;
    logic               first_sample_reg, first_sample_next;
    logic [11:0]        ir_left_cache_reg, ir_left_cache_next;
    logic [11:0]        ir_right_cache_reg, ir_right_cache_next;
    logic [11:0]        ir_front_cache_reg, ir_front_cache_next;

    logic               mid_valid_reg;
    mid_t               mid_reg, mid_next;
    logic               fire;

    logic signed [32:0] trav_l, trav_r;
    logic signed [33:0] trav_sum, trav_sum_adj, enc_diff, enc_diff_mag;
    logic signed [32:0] avg;
    logic signed [33:0] togo;
    logic signed [32:0] mag_l_full, mag_r_full;
    logic [32:0]        mag_sum;
    logic [31:0]        elapsed;
    logic               done, timed_out, enc_fault, front_hit;
    logic               refresh;
    logic [11:0]        eff_left, eff_right, eff_front;
    logic               wall_l, wall_r;
    logic signed [16:0] hd_diff, hd_adj;
    logic signed [31:0] remaining_sat;

    assign item_ready = !mid_valid_reg || mid_ready;
    assign fire       = item_valid && item_ready;
    assign mid_valid  = mid_valid_reg;
    assign mid        = mid_reg;

    // travel, average and distance to go, all kept wide
    always_comb
    begin
        trav_l = $signed({item.enc_left[31], item.enc_left})
               - $signed({left_origin_reg[31], left_origin_reg});
        trav_r = $signed({item.enc_right[31], item.enc_right})
               - $signed({right_origin_reg[31], right_origin_reg});
        trav_sum     = $signed({trav_l[32], trav_l}) + $signed({trav_r[32], trav_r});
        // halve toward zero
        trav_sum_adj = trav_sum + $signed({33'b0, trav_sum[33]});
        avg          = $signed(trav_sum_adj[33:1]);
        togo         = $signed({11'b0, cfg.target_counts}) - $signed({avg[32], avg});
        enc_diff     = $signed({trav_l[32], trav_l}) - $signed({trav_r[32], trav_r});
        enc_diff_mag = enc_diff[33] ? -enc_diff : enc_diff;

        mag_l_full = trav_l[32] ? -trav_l : trav_l;
        mag_r_full = trav_r[32] ? -trav_r : trav_r;
        mag_sum    = {1'b0, mag_l_full[31:0]} + {1'b0, mag_r_full[31:0]};

        elapsed   = item.time_ms - start_time_reg;
        done      = togo[33] || (togo == 34'sd0);
        timed_out = elapsed > {16'b0, cfg.timeout_ms};
        enc_fault = (elapsed > 32'(FAULT_GRACE_MS))
                 && (mag_sum > 33'(ENC_TRAV_SUM_MAX))
                 && (avg < $signed(33'(ENC_AVG_WINDOW)))
                 && (avg > -$signed(33'(ENC_AVG_WINDOW)));

        if (togo > $signed(34'h0_7FFF_FFFF))
            remaining_sat = 32'sh7FFF_FFFF;
        else if (togo < -$signed(34'h0_8000_0000))
            remaining_sat = -32'sh7FFF_FFFF - 32'sd1;
        else
            remaining_sat = togo[31:0];
    end

    // ir cache refresh, front check, side correction difference and heading difference
    always_comb
    begin
        phase_inc = (phase_reg == PHASE_LAST) ? '0 : phase_reg + 1'b1;
        refresh   = first_sample_reg || (phase_inc == '0);
        eff_left  = refresh ? item.ir_left  : ir_left_cache_reg;
        eff_right = refresh ? item.ir_right : ir_right_cache_reg;
        eff_front = refresh ? item.ir_front : ir_front_cache_reg;
        front_hit = eff_front >= cfg.front_stop_level;
        wall_l    = eff_left  > WALL_PRESENT_LEVEL;
        wall_r    = eff_right > WALL_PRESENT_LEVEL;

        hd_diff = $signed({item.heading[15], item.heading})
                - $signed({heading_target_reg[15], heading_target_reg});
        hd_adj  = hd_diff + $signed({15'b0, {2{hd_diff[16]}}});
    end

    always_comb
    begin
        active_next         = active_reg;
        left_origin_next    = left_origin_reg;
        right_origin_next   = right_origin_reg;
        heading_target_next = heading_target_reg;
        start_time_next     = start_time_reg;
        phase_next          = phase_reg;
        first_sample_next   = first_sample_reg;
        ir_left_cache_next  = ir_left_cache_reg;
        ir_right_cache_next = ir_right_cache_reg;
        ir_front_cache_next = ir_front_cache_reg;

        mid_next.status       = ST_DRIVING;
        mid_next.remaining    = remaining_sat;
        mid_next.base         = (togo < $signed({18'b0, cfg.slow_zone_counts}))
                              ? cfg.end_slow_pwm : cfg.cruise_pwm;
        mid_next.corr_h       = hd_adj[16:2];
        mid_next.enc_diff_q4  = enc_diff_mag[32:2];
        mid_next.enc_diff_neg = enc_diff[33];
        if (wall_l && wall_r)
            mid_next.ir_diff = $signed({1'b0, eff_right}) - $signed({1'b0, eff_left});
        else if (wall_l)
            mid_next.ir_diff = $signed({1'b0, cfg.side_target_level})
                             - $signed({1'b0, eff_left});
        else if (wall_r)
            mid_next.ir_diff = $signed({1'b0, eff_right})
                             - $signed({1'b0, cfg.side_target_level});
        else
            mid_next.ir_diff = 13'sd0;

        if (item.func == FUNC_START)
        begin
            mid_next.status     = ST_STARTED;
            mid_next.remaining  = $signed({9'b0, cfg.target_counts});
            left_origin_next    = item.enc_left;
            right_origin_next   = item.enc_right;
            heading_target_next = item.heading;
            start_time_next     = item.time_ms;
            active_next         = 1'b1;
            phase_next          = '0;
            first_sample_next   = 1'b1;
            ir_left_cache_next  = 12'd0;
            ir_right_cache_next = 12'd0;
            ir_front_cache_next = 12'd0;
        end
        else if (!active_reg)
        begin
            mid_next.status    = ST_IDLE;
            mid_next.remaining = 32'sd0;
        end
        else if (done)
        begin
            mid_next.status = ST_DONE;
            active_next     = 1'b0;
        end
        else if (timed_out)
        begin
            mid_next.status = ST_TIMEOUT;
            active_next     = 1'b0;
        end
        else if (enc_fault)
        begin
            mid_next.status = ST_ENCFAULT;
            active_next     = 1'b0;
        end
        else
        begin
            phase_next          = phase_inc;
            first_sample_next   = 1'b0;
            ir_left_cache_next  = eff_left;
            ir_right_cache_next = eff_right;
            ir_front_cache_next = eff_front;
            if (front_hit)
            begin
                mid_next.status = ST_FRONT;
                active_next     = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg         <= 1'b0;
            left_origin_reg    <= '0;
            right_origin_reg   <= '0;
            heading_target_reg <= '0;
            start_time_reg     <= '0;
            phase_reg          <= '0;
            first_sample_reg   <= 1'b1;
            ir_left_cache_reg  <= '0;
            ir_right_cache_reg <= '0;
            ir_front_cache_reg <= '0;
            mid_valid_reg      <= 1'b0;
        end
        else
        begin
            if (fire)
            begin
                active_reg         <= active_next;
                left_origin_reg    <= left_origin_next;
                right_origin_reg   <= right_origin_next;
                heading_target_reg <= heading_target_next;
                start_time_reg     <= start_time_next;
                phase_reg          <= phase_next;
                first_sample_reg   <= first_sample_next;
                ir_left_cache_reg  <= ir_left_cache_next;
                ir_right_cache_reg <= ir_right_cache_next;
                ir_front_cache_reg <= ir_front_cache_next;
            end
            if (item_ready)
                mid_valid_reg <= item_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
            mid_reg <= mid_next;
    end

    `SDSM_ASSERT_NEXT(a_start_arms, clk, rst_n, fire && item.func == FUNC_START, active_reg && first_sample_reg)
    `SDSM_ASSERT_NEXT(a_stop_disarms, clk, rst_n, fire && (mid_next.status == ST_DONE || mid_next.status == ST_TIMEOUT || mid_next.status == ST_ENCFAULT || mid_next.status == ST_FRONT), !active_reg)
    `SDSM_ASSERT_NEXT(a_idle_keeps_state, clk, rst_n, fire && item.func == FUNC_SAMPLE && !active_reg, $stable(left_origin_reg) && $stable(phase_reg) && $stable(ir_front_cache_reg))

endmodule

@@ rtl/sdsm_mix.sv @@
// mixing stages: constant divisions, correction sums, pwm saturation, result register
// depends on sdsm_pkg and the assertion macro header
`include "straight_drive_steering_mixer_assert.svh"

module sdsm_mix
    import sdsm_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  cfg_t    cfg,
    input  logic    mid_valid,
    output logic    mid_ready,
    input  mid_t    mid,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out
);

    typedef struct packed {
        status_t            status;
        logic signed [31:0] remaining;
        logic [7:0]         base;
        logic signed [14:0] corr_h;
        logic [8:0]         ir_q;
        logic               ir_neg;
        logic [28:0]        enc_q;
        logic               enc_neg;
    } prod_t;

    logic    prod_valid_reg;
    prod_t   prod_reg, prod_next;
    logic    out_valid_reg;
    result_t out_reg, out_next;
    logic    prod_ready, out_free;

    logic [12:0]        ir_mag_full;
    logic [24:0]        ir_prod;
    logic [62:0]        enc_prod;
    logic signed [31:0] ci, ce, ch, base, lim, sum_l, sum_r, pl, pr;

    assign out_free   = !out_valid_reg || out_ready;
    assign prod_ready = !prod_valid_reg || out_free;
    assign mid_ready  = prod_ready;
    assign out_valid  = out_valid_reg;
    assign out        = out_reg;

    // first stage: divisions by 10 and 20 as reciprocal multiplies
    always_comb
    begin
        ir_mag_full = mid.ir_diff[12] ? 13'(-mid.ir_diff) : 13'(mid.ir_diff);
        ir_prod     = {13'b0, ir_mag_full[11:0]} * {12'b0, DIV10_RECIP};
        enc_prod    = {32'b0, mid.enc_diff_q4} * {31'b0, DIV5_RECIP};

        prod_next.status    = mid.status;
        prod_next.remaining = mid.remaining;
        prod_next.base      = mid.base;
        prod_next.corr_h    = mid.corr_h;
        prod_next.ir_q      = ir_prod[DIV10_SHIFT +: 9];
        prod_next.ir_neg    = mid.ir_diff[12];
        prod_next.enc_q     = enc_prod[DIV5_SHIFT +: 29];
        prod_next.enc_neg   = mid.enc_diff_neg;
    end

    // second stage: sum the corrections, clamp to the pwm limit and zero the pwm unless driving
    always_comb
    begin
        base  = $signed({24'b0, prod_reg.base});
        ch    = $signed({{17{prod_reg.corr_h[14]}}, prod_reg.corr_h});
        ci    = prod_reg.ir_neg  ? -$signed({23'b0, prod_reg.ir_q})
                                 :  $signed({23'b0, prod_reg.ir_q});
        ce    = prod_reg.enc_neg ? -$signed({3'b0, prod_reg.enc_q})
                                 :  $signed({3'b0, prod_reg.enc_q});
        lim   = $signed({22'b0, cfg.pwm_max});
        sum_l = base + ch - ci - ce;
        sum_r = base - ch + ci + ce;

        if (sum_l > lim)
            pl = lim;
        else if (sum_l < -lim)
            pl = -lim;
        else
            pl = sum_l;

        if (sum_r > lim)
            pr = lim;
        else if (sum_r < -lim)
            pr = -lim;
        else
            pr = sum_r;

        out_next.status    = prod_reg.status;
        out_next.remaining = prod_reg.remaining;
        if (prod_reg.status == ST_DRIVING)
        begin
            out_next.pwm_left  = pl[10:0];
            out_next.pwm_right = pr[10:0];
        end
        else
        begin
            out_next.pwm_left  = 11'sd0;
            out_next.pwm_right = 11'sd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (prod_ready)
                prod_valid_reg <= mid_valid;
            if (out_free)
                out_valid_reg <= prod_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (prod_ready && mid_valid)
            prod_reg <= prod_next;
        if (out_free && prod_valid_reg)
            out_reg <= out_next;
    end

    `SDSM_ASSERT_NOW(a_stopped_pwm_zero, clk, rst_n, out_valid_reg && out_reg.status != ST_DRIVING, out_reg.pwm_left == 11'sd0 && out_reg.pwm_right == 11'sd0)

endmodule

@@ rtl/straight_drive_steering_mixer.sv @@
// top level of the straight drive steering mixer: input register, control and mixing stages
// depends on sdsm_pkg, sdsm_cfg, sdsm_ctrl and sdsm_mix
//
//   port group   dir   request moves
//   s_axis_*     in    one start or sample request, func in tuser
//   m_axis_*     out   one result per request, status in tuser
//   cfg_*        in    one register write (index, data)
//
// one request is accepted per cycle while no stall holds the pipeline; a result passes
// through the input register, control register, product register and output register
// the control stage updates the move state as a request leaves the input register,
// so back-to-back samples see the state left by the one before
// a stall on m_axis_tready propagates back stage by stage to s_axis_tready
// reset clears all valid flags and the move state; no clearing pass is needed
module straight_drive_steering_mixer
    import sdsm_pkg::*;
#(
    parameter int IR_REFRESH_EVERY = 3
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // time_ms[31:0], enc_left[63:32], enc_right[95:64], heading[111:96],
    // ir_left[123:112], ir_right[135:124], ir_front[147:136], zero pad
    input  logic [S_TDATA_W-1:0]   s_axis_tdata,
    // func
    input  logic                   s_axis_tuser,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // pwm_left[10:0], pwm_right[21:11], remaining[53:22], zero pad
    output logic [M_TDATA_W-1:0]   m_axis_tdata,
    // status
    output logic [2:0]             m_axis_tuser,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    cfg_t    cfg;
    logic    in_valid_reg;
    item_t   in_item_reg, in_item_next;
    logic    item_ready;
    logic    mid_valid, mid_ready;
    mid_t    mid;
    result_t result;

    assign s_axis_tready = !in_valid_reg || item_ready;

    always_comb
    begin
        in_item_next.func      = func_t'(s_axis_tuser);
        in_item_next.time_ms   = s_axis_tdata[31:0];
        in_item_next.enc_left  = s_axis_tdata[63:32];
        in_item_next.enc_right = s_axis_tdata[95:64];
        in_item_next.heading   = s_axis_tdata[111:96];
        in_item_next.ir_left   = s_axis_tdata[123:112];
        in_item_next.ir_right  = s_axis_tdata[135:124];
        in_item_next.ir_front  = s_axis_tdata[147:136];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_axis_tready)
            in_valid_reg <= s_axis_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
            in_item_reg <= in_item_next;
    end

    sdsm_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    sdsm_ctrl #(
        .IR_REFRESH_EVERY (IR_REFRESH_EVERY)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .item_valid (in_valid_reg),
        .item_ready (item_ready),
        .item       (in_item_reg),
        .mid_valid  (mid_valid),
        .mid_ready  (mid_ready),
        .mid        (mid)
    );

    sdsm_mix u_mix (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .mid_valid (mid_valid),
        .mid_ready (mid_ready),
        .mid       (mid),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out       (result)
    );

    assign m_axis_tdata = {2'b00, result.remaining, result.pwm_right, result.pwm_left};
    assign m_axis_tuser = result.status;

endmodule

@@ sim/sdsm_checker.sv @@
// scoreboard for the straight drive steering mixer: follows the request, result and register
// write channels, predicts each result and compares it field by field
// depends on sdsm_pkg; instantiated beside the block by testbench
module sdsm_checker
    import sdsm_pkg::*;
#(
    parameter int IR_REFRESH_EVERY = 3
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    input  logic                   s_axis_tready,
    input  logic [S_TDATA_W-1:0]   s_axis_tdata,
    input  logic                   s_axis_tuser,
    input  logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    input  logic [M_TDATA_W-1:0]   m_axis_tdata,
    input  logic [2:0]             m_axis_tuser,
    input  logic                   cfg_valid,
    input  logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output int unsigned            fail_count,
    output int unsigned            pending,
    output logic [6:0][15:0]       status_hits
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint      REM_MIN     = -64'sd2147483648;
    localparam longint      REM_MAX     = 64'sd2147483647;
    localparam logic [31:0] GRACE_MS    = 32'd500;
    localparam longint      TRAVEL_MIN  = 300;
    localparam longint      AVG_WINDOW  = 50;
    localparam logic [11:0] WALL_LEVEL  = 12'd100;

    cfg_t        regs;
    logic        move_active;
    longint      left_org;
    longint      right_org;
    longint      head_ref;
    logic [31:0] start_ms;
    int          ir_phase;
    logic        first_sample;
    logic [11:0] ir_cache [3];
    result_t     expected_drive [$];
    int unsigned errors;

    function automatic longint clamp(input longint v, input longint lo, input longint hi);
        if (v > hi)
            return hi;
        if (v < lo)
            return lo;
        return v;
    endfunction

    // works out the result of one request and advances the move state
    function automatic result_t predict_drive(input item_t req);
        longint      el;
        longint      er;
        longint      hd;
        longint      l;
        longint      r;
        longint      avg;
        longint      togo;
        longint      trav;
        longint      base;
        longint      ch;
        longint      ci;
        longint      ce;
        longint      lim;
        logic [31:0] elapsed;
        logic        wall_l;
        logic        wall_r;
        result_t     res;
        el  = longint'($signed(req.enc_left));
        er  = longint'($signed(req.enc_right));
        hd  = longint'($signed(req.heading));
        res = '0;
        if (req.func == FUNC_START)
        begin
            left_org     = el;
            right_org    = er;
            head_ref     = hd;
            start_ms     = req.time_ms;
            move_active  = 1'b1;
            ir_phase     = 0;
            first_sample = 1'b1;
            foreach (ir_cache[i])
                ir_cache[i] = '0;
            res.status    = ST_STARTED;
            res.remaining = 32'(regs.target_counts);
            return res;
        end
        if (!move_active)
        begin
            res.status = ST_IDLE;
            return res;
        end

        l    = el - left_org;
        r    = er - right_org;
        avg  = (l + r) / 2;
        togo = longint'(regs.target_counts) - avg;
        res.remaining = 32'(clamp(togo, REM_MIN, REM_MAX));
        elapsed = req.time_ms - start_ms;

        if (togo <= 0)
        begin
            move_active = 1'b0;
            res.status  = ST_DONE;
            return res;
        end
        if (elapsed > 32'(regs.timeout_ms))
        begin
            move_active = 1'b0;
            res.status  = ST_TIMEOUT;
            return res;
        end
        // wheels moving but the average stays near zero: one encoder counts backwards
        trav = ((l < 0 ? -l : l) + (r < 0 ? -r : r)) / 2;
        if (elapsed > GRACE_MS && trav > TRAVEL_MIN && avg < AVG_WINDOW && avg > -AVG_WINDOW)
        begin
            move_active = 1'b0;
            res.status  = ST_ENCFAULT;
            return res;
        end

        ir_phase = (ir_phase + 1) % IR_REFRESH_EVERY;
        if (first_sample || ir_phase == 0)
        begin
            ir_cache[0] = req.ir_left;
            ir_cache[1] = req.ir_right;
            ir_cache[2] = req.ir_front;
        end
        first_sample = 1'b0;

        if (ir_cache[2] >= regs.front_stop_level)
        begin
            move_active = 1'b0;
            res.status  = ST_FRONT;
            return res;
        end

        base = (togo < longint'(regs.slow_zone_counts)) ? longint'(regs.end_slow_pwm)
                                                         : longint'(regs.cruise_pwm);
        ch = (hd - head_ref) / 4;

        wall_l = ir_cache[0] > WALL_LEVEL;
        wall_r = ir_cache[1] > WALL_LEVEL;
        ci = 0;
        if (wall_l && wall_r)
            ci = (longint'(ir_cache[1]) - longint'(ir_cache[0])) / 10;
        else if (wall_l)
            ci = (longint'(regs.side_target_level) - longint'(ir_cache[0])) / 10;
        else if (wall_r)
            ci = (longint'(ir_cache[1]) - longint'(regs.side_target_level)) / 10;

        ce  = (l - r) / 20;
        lim = longint'(regs.pwm_max);
        res.pwm_left  = 11'(clamp(base + ch - ci - ce, -lim, lim));
        res.pwm_right = 11'(clamp(base - ch + ci + ce, -lim, lim));
        res.status    = ST_DRIVING;
        return res;
    endfunction

    task automatic flag_mismatch(input string field, input longint want, input longint got);
        errors++;
        $error("%s mismatch: expected %0d, actual %0d", field, want, got);
    endtask

    always @(posedge clk or negedge rst_n)
    begin : monitor
        item_t   req;
        result_t want;
        if (!rst_n)
        begin
            regs.target_counts     = '0;
            regs.cruise_pwm        = '0;
            regs.timeout_ms        = 16'd2000;
            regs.pwm_max           = 10'd255;
            regs.end_slow_pwm      = 8'd60;
            regs.slow_zone_counts  = '0;
            regs.front_stop_level  = 12'hFFF;
            regs.side_target_level = '0;
            move_active  = 1'b0;
            left_org     = 0;
            right_org    = 0;
            head_ref     = 0;
            start_ms     = '0;
            ir_phase     = 0;
            first_sample = 1'b1;
            foreach (ir_cache[i])
                ir_cache[i] = '0;
            expected_drive.delete();
            errors      = 0;
            fail_count  <= 0;
            pending     <= 0;
            status_hits <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_TARGET_COUNTS:    regs.target_counts     = cfg_data[22:0];
                    REG_CRUISE_PWM:       regs.cruise_pwm        = cfg_data[7:0];
                    REG_TIMEOUT_MS:       regs.timeout_ms        = cfg_data[15:0];
                    REG_PWM_MAX:          regs.pwm_max           = cfg_data[9:0];
                    REG_END_SLOW_PWM:     regs.end_slow_pwm      = cfg_data[7:0];
                    REG_SLOW_ZONE_COUNTS: regs.slow_zone_counts  = cfg_data[15:0];
                    REG_FRONT_STOP_LEVEL: regs.front_stop_level  = cfg_data[11:0];
                    REG_SIDE_TARGET:      regs.side_target_level = cfg_data[11:0];
                    default: ;
                endcase
            end

            if (m_axis_tvalid && m_axis_tready)
            begin
                if (m_axis_tuser <= 3'd6)
                    status_hits[m_axis_tuser] <= status_hits[m_axis_tuser] + 16'd1;
                if (expected_drive.size() == 0)
                begin
                    errors++;
                    $error("result with no request outstanding, status %0d", m_axis_tuser);
                end
                else
                begin
                    want = expected_drive.pop_front();
                    if (m_axis_tdata[10:0] !== want.pwm_left)
                        flag_mismatch("pwm_left", longint'(want.pwm_left),
                                      longint'($signed(m_axis_tdata[10:0])));
                    if (m_axis_tdata[21:11] !== want.pwm_right)
                        flag_mismatch("pwm_right", longint'(want.pwm_right),
                                      longint'($signed(m_axis_tdata[21:11])));
                    if (m_axis_tuser !== want.status)
                        flag_mismatch("status", longint'(want.status), longint'(m_axis_tuser));
                    if (m_axis_tdata[53:22] !== want.remaining)
                        flag_mismatch("remaining", longint'(want.remaining),
                                      longint'($signed(m_axis_tdata[53:22])));
                end
            end

            if (s_axis_tvalid && s_axis_tready)
            begin
                req.func      = func_t'(s_axis_tuser);
                req.time_ms   = s_axis_tdata[31:0];
                req.enc_left  = s_axis_tdata[63:32];
                req.enc_right = s_axis_tdata[95:64];
                req.heading   = s_axis_tdata[111:96];
                req.ir_left   = s_axis_tdata[123:112];
                req.ir_right  = s_axis_tdata[135:124];
                req.ir_front  = s_axis_tdata[147:136];
                expected_drive.push_back(predict_drive(req));
            end

            fail_count <= errors;
            pending    <= expected_drive.size();
        end
    end

endmodule

@@ sim/testbench.sv @@
// top of the straight drive steering mixer testbench: clock, reset, request and register
// stimulus with random gaps and stalls, and the final verdict
// depends on sdsm_pkg, straight_drive_steering_mixer and sdsm_checker
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import sdsm_pkg::*;

    localparam int CLK_PERIOD   = 20;
    localparam int HOLD_CYCLES  = 6;
    localparam int PHASES       = 8;
    localparam int PHASE_ITEMS  = 105;
    localparam int LIMIT_CYCLES = 200_000;

    localparam logic signed [31:0] ENC_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] ENC_MAX = 32'sh7FFF_FFFF;

    typedef enum int {
        MOVE_STRAIGHT,
        MOVE_SPIN,
        MOVE_STALL
    } move_kind_t;

    logic                   clk           = 1'b0;
    logic                   rst_n         = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [S_TDATA_W-1:0]   s_axis_tdata  = '0;
    logic                   s_axis_tuser  = 1'b0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0]   m_axis_tdata;
    logic [2:0]             m_axis_tuser;
    logic                   cfg_valid     = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index     = '0;
    logic [CFG_DATA_W-1:0]  cfg_data      = '0;

    int unsigned      fail_count;
    int unsigned      pending;
    logic [6:0][15:0] status_hits;

    logic stall_on = 1'b1;
    bit   gaps_on  = 1'b1;
    int   req_count;
    int   move_count;
    int   cfg_writes;

    straight_drive_steering_mixer dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    sdsm_checker chk (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .fail_count    (fail_count),
        .pending       (pending),
        .status_hits   (status_hits)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    always @(posedge clk)
        m_axis_tready <= stall_on ? ($urandom_range(99) >= 15) : 1'b1;

    initial
    begin
        #(LIMIT_CYCLES * CLK_PERIOD);
        $display("run limit reached with %0d results outstanding", pending);
        $display("*** FAILED ***");
        $finish;
    end

    task automatic send_req(input func_t f, input logic [31:0] t,
                            input logic signed [31:0] el, input logic signed [31:0] er,
                            input logic signed [15:0] hd, input logic [11:0] il,
                            input logic [11:0] ir, input logic [11:0] ifr);
        // junk on the bus while idle must be ignored
        while (gaps_on && $urandom_range(99) < 15)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= {$urandom, $urandom, $urandom, $urandom, 24'($urandom)};
            s_axis_tuser  <= 1'($urandom);
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= f;
        s_axis_tdata  <= {4'd0, ifr, ir, il, hd, er, el, t};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        req_count++;
    endtask

    // waits until every request has its result, then lets the pipeline settle
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (HOLD_CYCLES)
            @(posedge clk);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [22:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
        cfg_writes++;
    endtask

    task automatic apply_config(input logic [22:0] target, input logic [22:0] cruise,
                                input logic [22:0] timeout, input logic [22:0] limit,
                                input logic [22:0] slow_pwm, input logic [22:0] slow_zone,
                                input logic [22:0] front_stop, input logic [22:0] side_level);
        drain();
        write_reg(REG_TARGET_COUNTS, target);
        write_reg(REG_CRUISE_PWM, cruise);
        write_reg(REG_TIMEOUT_MS, timeout);
        write_reg(REG_PWM_MAX, limit);
        write_reg(REG_END_SLOW_PWM, slow_pwm);
        write_reg(REG_SLOW_ZONE_COUNTS, slow_zone);
        write_reg(REG_FRONT_STOP_LEVEL, front_stop);
        write_reg(REG_SIDE_TARGET, side_level);
    endtask

    // register value: zero or all ones now and then, otherwise a usable range
    function automatic logic [22:0] pick_reg(input int width, input int lo, input int hi);
        int roll;
        roll = $urandom_range(99);
        if (roll < 10)
            return '0;
        if (roll < 20)
            return 23'((1 << width) - 1);
        return 23'($urandom_range(hi, lo));
    endfunction

    task automatic run_move(input move_kind_t kind, input int samples);
        logic [31:0]        t;
        logic signed [31:0] el;
        logic signed [31:0] er;
        logic signed [15:0] h0;
        logic signed [15:0] hd;
        logic [11:0]        il;
        logic [11:0]        ir;
        logic [11:0]        ifr;
        int                 step;
        t  = $urandom;
        el = $urandom;
        er = $urandom;
        h0 = 16'($urandom);
        send_req(FUNC_START, t, el, er, h0, 12'($urandom), 12'($urandom), 12'($urandom));
        move_count++;
        for (int i = 0; i < samples; i++)
        begin
            case (kind)
                MOVE_SPIN:
                begin
                    // wheels turn against each other: polarity fault once past the grace time
                    t   += $urandom_range(150, 1);
                    step = $urandom_range(120, 20);
                    el  += step;
                    er  -= step + int'($urandom_range(8));
                end
                MOVE_STALL:
                begin
                    t  += $urandom_range(200, 1);
                    el += int'($urandom_range(4)) - 2;
                    er += int'($urandom_range(4)) - 2;
                end
                default:
                begin
                    t   += $urandom_range(60, 1);
                    step = $urandom_range(120);
                    el  += step + int'($urandom_range(10)) - 5;
                    er  += step + int'($urandom_range(10)) - 5;
                end
            endcase
            if ($urandom_range(19) == 0)
                hd = 16'($urandom);
            else
                hd = h0 + 16'(int'($urandom_range(400)) - 200);
            il  = $urandom_range(1) ? 12'($urandom_range(100)) : 12'($urandom);
            ir  = $urandom_range(1) ? 12'($urandom_range(100)) : 12'($urandom);
            ifr = ($urandom_range(9) == 0) ? 12'($urandom) : 12'($urandom_range(1200));
            send_req(FUNC_SAMPLE, t, el, er, hd, il, ir, ifr);
        end
    endtask

    initial
    begin : stimulus
        int         phase_start;
        int         roll;
        move_kind_t kind;

        repeat (4)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // sample before any move has started
        send_req(FUNC_SAMPLE, '1, ENC_MAX, ENC_MIN, 16'sh8000, 12'hFFF, 12'hFFF, 12'hFFF);

        // widest settings; time wraps past zero inside the move
        apply_config(23'h7F_FFFF, 23'd255, 23'd65535, 23'd1023, 23'd0, 23'd65535,
                     23'd4095, 23'd4095);
        send_req(FUNC_START, 32'hFFFF_FF00, ENC_MIN, ENC_MAX, 16'sh7FFF, '0, '0, '0);
        send_req(FUNC_SAMPLE, 32'h10, ENC_MIN + 4000, ENC_MAX - 3990, 16'sh8000,
                 12'hFFF, 12'hFFF, 12'h000);
        // front value here is not refreshed into the cache
        send_req(FUNC_SAMPLE, 32'h300, ENC_MIN + 200, ENC_MAX - 200, 16'sh7FFF,
                 12'd2000, 12'd0, 12'hFFF);
        send_req(FUNC_SAMPLE, 32'h400, ENC_MIN + 400, ENC_MAX - 380, 16'sh7FFF,
                 12'd0, 12'd0, 12'd0);
        send_req(FUNC_SAMPLE, 32'h0, 32'sd0, 32'sd0, 16'sd0, 12'd0, 12'd0, 12'd0);

        // zero target finishes at once
        apply_config(23'd0, 23'd100, 23'd0, 23'd1023, 23'd30, 23'd50, 23'd1000, 23'd500);
        send_req(FUNC_START, 32'd1000, 32'sd5, 32'sd5, 16'sd0, 12'd0, 12'd0, 12'd0);
        send_req(FUNC_SAMPLE, 32'd1000, 32'sd5, 32'sd5, 16'sd0, 12'd0, 12'd0, 12'd0);

        // zero timeout: front wall on the first sample, then a timeout
        apply_config(23'd100, 23'd100, 23'd0, 23'd1023, 23'd30, 23'd50, 23'd1000, 23'd500);
        send_req(FUNC_START, 32'd500, 32'sd0, 32'sd0, 16'sd0, 12'd0, 12'd0, 12'd0);
        send_req(FUNC_SAMPLE, 32'd500, 32'sd0, 32'sd0, 16'sd0, 12'd0, 12'd0, 12'hFFF);
        send_req(FUNC_START, 32'd500, 32'sd0, 32'sd0, 16'sd0, 12'd0, 12'd0, 12'd0);
        send_req(FUNC_SAMPLE, 32'd501, 32'sd0, 32'sd0, 16'sd0, 12'd0, 12'd0, 12'd0);

        // one move through right wall, left wall, no wall, slow zone and done
        apply_config(23'd100, 23'd100, 23'd2000, 23'd1023, 23'd30, 23'd50, 23'd1000, 23'd500);
        send_req(FUNC_START, 32'd0, 32'sd0, 32'sd0, 16'sd0, 12'd0, 12'd0, 12'd0);
        send_req(FUNC_SAMPLE, 32'd10, 32'sd10, 32'sd10, 16'sd0, 12'd50, 12'hFFF, 12'd0);
        send_req(FUNC_SAMPLE, 32'd20, 32'sd20, 32'sd21, 16'sd0, 12'd0, 12'd0, 12'hFFF);
        send_req(FUNC_SAMPLE, 32'd30, 32'sd60, 32'sd62, 16'sd0, 12'd101, 12'd100, 12'd999);
        send_req(FUNC_SAMPLE, 32'd40, 32'sd70, 32'sd70, -16'sd100, 12'hFFF, 12'hFFF, 12'hFFF);
        send_req(FUNC_SAMPLE, 32'd50, 32'sd80, 32'sd80, 16'sd50, 12'hFFF, 12'hFFF, 12'hFFF);
        send_req(FUNC_SAMPLE, 32'd60, 32'sd95, 32'sd96, 16'sd0, 12'd100, 12'd100, 12'd0);
        send_req(FUNC_SAMPLE, 32'd70, ENC_MIN, ENC_MAX, 16'sd0, 12'd0, 12'd0, 12'd0);
        send_req(FUNC_SAMPLE, 32'd80, 32'sd200, 32'sd200, 16'sd0, 12'd0, 12'd0, 12'd0);

        // remaining beyond the 32-bit range both ways
        send_req(FUNC_START, 32'd0, ENC_MAX, ENC_MAX, 16'sd0, 12'd0, 12'd0, 12'd0);
        send_req(FUNC_SAMPLE, 32'd5, ENC_MIN, ENC_MIN, 16'sd0, 12'd0, 12'd0, 12'd0);
        send_req(FUNC_START, 32'd0, ENC_MIN, ENC_MIN, 16'sd0, 12'd0, 12'd0, 12'd0);
        send_req(FUNC_SAMPLE, 32'd5, ENC_MAX, ENC_MAX, 16'sd0, 12'd0, 12'd0, 12'd0);

        for (int ph = 0; ph < PHASES; ph++)
        begin
            // one phase runs without gaps or stalls
            stall_on <= (ph != 3);
            gaps_on   = (ph != 3);
            if (ph == 1)
                apply_config(pick_reg(23, 100, 4000), 23'd0, pick_reg(16, 300, 2500), 23'd0,
                             23'd255, 23'd0, pick_reg(12, 1500, 4095), 23'd0);
            else
                apply_config(pick_reg(23, 100, 4000), pick_reg(8, 0, 255),
                             pick_reg(16, 300, 2500), pick_reg(10, 0, 1023),
                             pick_reg(8, 0, 255), pick_reg(16, 0, 1500),
                             pick_reg(12, 1500, 4095), pick_reg(12, 0, 4095));
            phase_start = req_count;
            while (req_count - phase_start < PHASE_ITEMS)
            begin
                roll = $urandom_range(99);
                if (roll < 15)
                    send_req(func_t'($urandom_range(1)), $urandom, $urandom, $urandom,
                             16'($urandom), 12'($urandom), 12'($urandom), 12'($urandom));
                else
                begin
                    roll = $urandom_range(99);
                    if (roll < 70)
                        kind = MOVE_STRAIGHT;
                    else if (roll < 85)
                        kind = MOVE_SPIN;
                    else
                        kind = MOVE_STALL;
                    run_move(kind, $urandom_range(30, 2));
                end
            end
        end

        drain();
        $display("run covered %0d requests over %0d random moves, %0d register writes",
                 req_count, move_count, cfg_writes);
        $display("statuses: driving %0d done %0d timeout %0d enc fault %0d front %0d %s %0d %s %0d",
                 status_hits[0], status_hits[1], status_hits[2], status_hits[3],
                 status_hits[4], "started", status_hits[5], "idle", status_hits[6]);
        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

@@ straight_drive_steering_mixer.f @@
+incdir+rtl
rtl/sdsm_pkg.sv
rtl/sdsm_cfg.sv
rtl/sdsm_ctrl.sv
rtl/sdsm_mix.sv
rtl/straight_drive_steering_mixer.sv
sim/sdsm_checker.sv
sim/testbench.sv
